// File: src/osvf_pkg.sv
// ---------------------------------------------------------------------------
// osvf_pkg: shared types and constants of the decaying oscillator filter core
// Holds widths, register indexes, selector codes, divider interface structs
// and the 32-bit saturation helper.
// ---------------------------------------------------------------------------
package osvf_pkg;

	// filter cascade depth and stage index width
	localparam int STAGES = 4;
	localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_WAVE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LEN = 3'd5;

	// waveform and filter tap codes
	localparam logic [1:0] WAVE_SAW    = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_TRI    = 2'd2;

	localparam logic [1:0] FILT_LOW  = 2'd0;
	localparam logic [1:0] FILT_BAND = 2'd1;
	localparam logic [1:0] FILT_HIGH = 2'd2;

	// envelope ratio, Q1.16
	localparam int RATIO_W   = 17;
	localparam int LEN_W     = 16;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] ratio;
	} div_rsp_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
		logic signed [31:0] r;
		if (x > 38'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (x < -38'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/osvf_env_div.sv
// ---------------------------------------------------------------------------
// osvf_env_div: envelope ratio divider
// Radix-2 restoring divider giving floor(pos * 2^16 / len), capped at 1.0; zero when len is zero.
// ---------------------------------------------------------------------------
module osvf_env_div (
	input  logic               clk,
	input  logic               arst_n,
	input  osvf_pkg::div_req_t req,
	output osvf_pkg::div_rsp_t rsp
);
	import osvf_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     quo_q;
	logic [RATIO_W-1:0]   ratio_q;
	logic [LEN_W:0]       rem_sh;
	logic                 qbit;

	// one quotient bit per cycle
	assign rem_sh = {rem_q, 1'b0};
	assign qbit   = (rem_sh >= {1'b0, req.len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.len == '0 || req.pos >= req.len) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.pos;
			quo_q <= '0;
			if (req.len == '0) begin
				ratio_q <= '0;
			end else if (req.pos >= req.len) begin
				ratio_q <= RATIO_ONE;
			end
		end else if (busy_q) begin
			rem_q <= qbit ? LEN_W'(rem_sh - {1'b0, req.len}) : rem_sh[LEN_W-1:0];
			quo_q <= {quo_q[LEN_W-2:0], qbit};
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				ratio_q <= {1'b0, quo_q[LEN_W-2:0], qbit};
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.ratio = ratio_q;

endmodule

// File: src/osc_env_cascaded_svf_core.sv
// ---------------------------------------------------------------------------
// osc_env_cascaded_svf_core: decaying oscillator through cascaded SVF stages
// One sample per input transaction: saw/square/triangle oscillator, squared
// decay envelope, a cascade of Chamberlin state-variable filter stages kept
// in a small synchronous memory, and a clamped 16-bit output.
// ---------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  config   | cfg_wr_en             | cfg_index[2:0], cfg_data[22:0]
//  input    | in_valid / in_ready   | restart_note
//  output   | out_valid / out_ready | audio_out[15:0] signed, note_last
//
//  The sample time is set by the 16-step envelope divider and the single
//  shared 33x18 multiplier, used three times per filter stage; the divider
//  steps are skipped when the note length is zero or the envelope position
//  is at/over it.
//  Reset: arst_n clears control, envelope and per-stage valid bits, sets
//  config, phase to defaults; invalid stage rows read as zero, so no sweep.
//  Stalls: the output register holds a result while out_ready is low; the
//  next sample is accepted meanwhile and waits in its last state until the
//  output register frees.
// ---------------------------------------------------------------------------
module osc_env_cascaded_svf_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_wr_en,
	input  logic [osvf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osvf_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample request
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               restart_note,
	// sample result
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [15:0]                 audio_out,
	output logic                               note_last
);
	import osvf_pkg::*;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_SQR  = 4'd2;
	localparam logic [3:0] ST_VOL  = 4'd3;
	localparam logic [3:0] ST_OM   = 4'd4;
	localparam logic [3:0] ST_OS   = 4'd5;
	localparam logic [3:0] ST_RD   = 4'd6;
	localparam logic [3:0] ST_LD   = 4'd7;
	localparam logic [3:0] ST_HI   = 4'd8;
	localparam logic [3:0] ST_M2   = 4'd9;
	localparam logic [3:0] ST_BD   = 4'd10;
	localparam logic [3:0] ST_M3   = 4'd11;
	localparam logic [3:0] ST_LO   = 4'd12;
	localparam logic [3:0] ST_FIN  = 4'd13;

	// configuration registers
	logic [1:0]             wave_q;
	logic [1:0]             filt_q;
	logic [15:0]            cutoff_q;
	logic [15:0]            damping_q;
	logic [CFG_DATA_W-1:0]  step_q;
	logic [LEN_W-1:0]       note_len_q;

	// oscillator and envelope state
	logic signed [23:0]     osc_phase_q;
	logic [LEN_W-1:0]       env_pos_q;
	logic                   last_q;

	// sequencer and working registers
	logic [3:0]             state_q;
	logic [STG_W-1:0]       stg_q;
	logic [RATIO_W-1:0]     ratio_q;
	logic [RATIO_W-1:0]     vol_q;
	logic signed [31:0]     s_q;
	logic signed [31:0]     low_q;
	logic signed [31:0]     band_q;
	logic signed [31:0]     high_q;
	logic signed [50:0]     mul_q;

	// stage state memory: one row of {low, band} per stage
	logic [63:0]            stmem [STAGES];
	logic [63:0]            rd_data_q;
	logic                   rd_vld_q;
	logic [STAGES-1:0]      row_vld_q;
	logic                   mem_we;
	logic [63:0]            mem_wdata;

	// output register
	logic                   out_valid_q;
	logic signed [15:0]     audio_q;
	logic                   note_last_q;

	// combinational helpers
	logic                   accept;
	logic [LEN_W-1:0]       pos_now;
	div_req_t               div_req;
	div_rsp_t               div_rsp;
	logic signed [32:0]     mul_a;
	logic signed [17:0]     mul_b;
	logic signed [25:0]     tri_t;
	logic [22:0]            step_sat;
	logic signed [24:0]     phase_sum;
	logic signed [24:0]     phase_next;
	logic [31:0]            sq_mag;
	logic signed [31:0]     sq_sample;
	logic signed [31:0]     low_rd;
	logic signed [31:0]     band_rd;
	logic signed [31:0]     high_new;
	logic signed [31:0]     band_new;
	logic signed [31:0]     low_new;
	logic signed [31:0]     stage_out;
	logic [46:0]            sc_prod;
	logic [22:0]            y_pos;
	logic signed [32:0]     s_ext;
	logic [32:0]            neg_mag;
	logic [23:0]            y_mag;
	logic signed [15:0]     y_out;
	logic                   out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// a restart reloads the position before this sample uses it
	assign pos_now = restart_note ? note_len_q : env_pos_q;

	// envelope ratio divider
	assign div_req.start = accept;
	assign div_req.pos   = pos_now;
	assign div_req.len   = note_len_q;

	osvf_env_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes; the host must write only while no sample is in flight (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q     <= WAVE_SQUARE;
			filt_q     <= FILT_LOW;
			cutoff_q   <= 16'd32768;
			damping_q  <= 16'd16384;
			step_q     <= '0;
			note_len_q <= 16'd22050;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WAVE:     wave_q     <= cfg_data[1:0];
				REG_FILTER:   filt_q     <= cfg_data[1:0];
				REG_CUTOFF:   cutoff_q   <= cfg_data[15:0];
				REG_DAMPING:  damping_q  <= cfg_data[15:0];
				REG_STEP:     step_q     <= cfg_data;
				REG_NOTE_LEN: note_len_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// triangle fold: past +/-0.5, subtract the phase from +/-0.5
	always_comb begin
		if (osc_phase_q > 24'sd2097152) begin
			tri_t = 26'sd2097152 - 26'(osc_phase_q);
		end else if (osc_phase_q < -24'sd2097152) begin
			tri_t = -26'sd2097152 - 26'(osc_phase_q);
		end else begin
			tri_t = 26'(osc_phase_q);
		end
	end

	// phase advance: clamp the step to 1.0, wrap by -2.0 past +1.0
	assign step_sat  = (step_q > 23'd4194304) ? 23'd4194304 : step_q;
	assign phase_sum = 25'(osc_phase_q) + $signed({2'b00, step_sat});
	assign phase_next = (phase_sum > 25'sd4194304) ? (phase_sum - 25'sd8388608) : phase_sum;

	// square: +vol or -vol moved to Q7.24
	assign sq_mag    = {7'd0, vol_q, 8'd0};
	assign sq_sample = (osc_phase_q > 24'sd0) ? $signed(sq_mag) : -$signed(sq_mag);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQR: begin
				mul_a = $signed({16'd0, ratio_q});
				mul_b = $signed({1'b0, ratio_q});
			end
			ST_OM: begin
				mul_a = (wave_q == WAVE_TRI) ? (33'(tri_t) <<< 1) : 33'(osc_phase_q);
				mul_b = $signed({1'b0, vol_q});
			end
			ST_LD: begin
				mul_a = 33'(band_rd);
				mul_b = $signed({2'b00, damping_q});
			end
			ST_M2: begin
				mul_a = 33'(high_q);
				mul_b = $signed({2'b00, cutoff_q});
			end
			ST_M3: begin
				mul_a = 33'(band_q);
				mul_b = $signed({2'b00, cutoff_q});
			end
			default: ;
		endcase
	end

	// widen both operands so the full product is kept
	always_ff @(posedge clk) begin
		mul_q <= 51'(mul_a) * 51'(mul_b);
	end

	// stage arithmetic; every shift of a product floors
	assign low_rd   = rd_vld_q ? $signed(rd_data_q[63:32]) : 32'sd0;
	assign band_rd  = rd_vld_q ? $signed(rd_data_q[31:0]) : 32'sd0;
	assign high_new = sat32(38'(s_q) - 38'($signed(mul_q[50:14])) - 38'(low_q));
	assign band_new = sat32(38'(band_q) + 38'($signed(mul_q[50:16])));
	assign low_new  = sat32(38'(low_q) + 38'($signed(mul_q[50:16])));

	always_comb begin
		case (filt_q)
			FILT_BAND: stage_out = band_q;
			FILT_HIGH: stage_out = high_q;
			default:   stage_out = low_new;
		endcase
	end

	assign mem_we    = (state_q == ST_LO);
	assign mem_wdata = {low_new, band_q};

	// stage memory: write back in ST_LO, read in ST_RD; a row is never read
	// again until the next sample, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stmem[stg_q] <= mem_wdata;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= stmem[stg_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[stg_q] <= 1'b1;
			end
			if (state_q == ST_RD) begin
				rd_vld_q <= row_vld_q[stg_q];
			end
		end
	end

	// output scaling: positive by 32767/2^24, otherwise by 1/512, toward zero
	assign sc_prod = ({16'd0, s_q[30:0]} << 15) - {16'd0, s_q[30:0]};
	assign y_pos   = sc_prod[46:24];
	assign s_ext   = 33'(s_q);
	assign neg_mag = -s_ext;
	assign y_mag   = neg_mag[32:9];

	always_comb begin
		if (s_q > 32'sd0) begin
			y_out = (y_pos > 23'd32767) ? 16'sh7FFF : $signed(y_pos[15:0]);
		end else begin
			y_out = (y_mag >= 24'd32768) ? 16'sh8000 : -$signed(y_mag[15:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stg_q       <= '0;
			osc_phase_q <= -24'sd4194304;
			env_pos_q   <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished sample, or drop the one just taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// count the envelope down, hold at zero
						env_pos_q <= (pos_now != '0) ? pos_now - 1'b1 : '0;
						last_q    <= (pos_now == LEN_W'(1));
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: state_q <= ST_VOL;
				ST_VOL: state_q <= ST_OM;
				ST_OM: begin
					// the multiplier has captured the old phase; advance it
					osc_phase_q <= phase_next[23:0];
					state_q     <= ST_OS;
				end
				ST_OS: begin
					stg_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_LD;
				ST_LD: state_q <= ST_HI;
				ST_HI: state_q <= ST_M2;
				ST_M2: state_q <= ST_BD;
				ST_BD: state_q <= ST_M3;
				ST_M3: state_q <= ST_LO;
				ST_LO: begin
					if (stg_q == STG_W'(STAGES - 1)) begin
						state_q <= ST_FIN;
					end else begin
						stg_q   <= stg_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					// hold until the output register frees
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIV: begin
				if (div_rsp.done) begin
					ratio_q <= div_rsp.ratio;
				end
			end
			ST_VOL: vol_q <= mul_q[32:16];
			ST_OM: begin
				s_q <= (wave_q == WAVE_SQUARE) ? sq_sample : 32'sd0;
			end
			ST_OS: begin
				if (wave_q == WAVE_SAW || wave_q == WAVE_TRI) begin
					s_q <= $signed(mul_q[45:14]);
				end
			end
			ST_LD: begin
				low_q  <= low_rd;
				band_q <= band_rd;
			end
			ST_HI: high_q <= high_new;
			ST_BD: band_q <= band_new;
			ST_LO: begin
				low_q <= low_new;
				s_q   <= stage_out;
			end
			ST_FIN: begin
				if (out_free) begin
					audio_q     <= y_out;
					note_last_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign audio_out = audio_q;
	assign note_last = note_last_q;

	// checks
	a_ratio_cap: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> div_rsp.ratio <= RATIO_ONE)
		else $error("envelope ratio above 1.0");

	a_vol_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_VOL |=> vol_q <= RATIO_ONE)
		else $error("volume above 1.0");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		osc_phase_q <= 24'sd4194304 && osc_phase_q >= -24'sd4194304)
		else $error("oscillator phase out of range");

	a_stage_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> stg_q == STG_W'(STAGES - 1))
		else $error("cascade finished early");

endmodule

// File: verif/osc_env_cascaded_svf_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// osc_env_cascaded_svf_core_test: self-checking bench of the SVF sample core
// Programs waveform, filter tap, coefficients, phase step and note length
// while the core is idle. It then requests samples with random note restarts
// and compares every sample and end-of-note flag with a bit-exact model of
// the oscillator, envelope and filter cascade kept inside the bench, or with fixed values on typed rows.
// ---------------------------------------------------------------------------
module osc_env_cascaded_svf_core_test;
	import osvf_pkg::*;

	localparam int     SAMPLE_TARGET = 950;
	localparam int     DRAIN_CYCLES  = 64;          // above the sample time of the core
	localparam int     TIMEOUT_NS    = 12_000_000;  // overall time limit of the run
	localparam int     PHASE_ONE     = 4194304;     // 1.0 in Q2.22
	localparam int     PHASE_HALF    = 2097152;
	localparam int     PHASE_TWO     = 8388608;
	localparam longint WORD_MAX      = 64'sd2147483647;
	localparam longint WORD_MIN      = -64'sd2147483648;

	typedef struct {
		logic signed [15:0] audio;
		logic               last;
	} sample_t;

	typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  restart;
		bit                    typed;
		sample_t               want;
	} row_t;

	// block ports; every input known from time zero
	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  restart_note = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic signed [15:0]    audio_out;
	logic                  note_last;

	// bench copy of the settings, at their reset values
	logic [1:0]            wave_sel  = WAVE_SQUARE;
	logic [1:0]            filt_sel  = FILT_LOW;
	logic [15:0]           cutoff_q  = 16'd32768;
	logic [15:0]           damping_q = 16'd16384;
	logic [22:0]           step_q    = 23'd0;
	logic [15:0]           len_q     = 16'd22050;

	// bench copy of the sample state, at its reset values
	int                    phase_acc = -PHASE_ONE;
	int                    env_left  = 0;
	int                    low_st  [STAGES] = '{default: 0};
	int                    band_st [STAGES] = '{default: 0};

	sample_t               expected_samples [$];
	row_t                  stimulus_rows [$];
	int                    samples_sent   = 0;
	int                    mismatch_count = 0;
	bit                    steady_flow    = 1'b0;

	osc_env_cascaded_svf_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart_note (restart_note),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.audio_out    (audio_out),
		.note_last    (note_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the handshake locks up
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	function automatic longint clamp_word(input longint x);
		if (x > WORD_MAX) begin
			return WORD_MAX;
		end else if (x < WORD_MIN) begin
			return WORD_MIN;
		end
		return x;
	endfunction

	// Advance the bench state by one sample and return what the core must emit.
	// All shifts are arithmetic on signed 64-bit values, i.e. floors.
	function automatic sample_t compute_sample(input logic restart);
		sample_t res;
		longint  vol, s, t, y, p, lo, bd, hi, cut, damp, len, pos, ratio, stepv;
		int      k;
		vol  = 0;
		s    = 0;
		cut  = longint'(cutoff_q);
		damp = longint'(damping_q);
		len  = longint'(len_q);
		if (restart) begin
			env_left = int'(len_q);
		end
		pos = longint'(env_left);

		// squared decay envelope; a zero length stays silent
		if (len != 0) begin
			ratio = (pos << 16) / len;
			if (ratio > 65536) begin
				ratio = 65536;
			end
			vol = (ratio * ratio) >>> 16;
		end

		case (wave_sel)
			WAVE_SAW: begin
				s = (longint'(phase_acc) * vol) >>> 14;
			end
			WAVE_SQUARE: begin
				s = (phase_acc > 0) ? vol * 256 : -vol * 256;
			end
			WAVE_TRI: begin
				if (phase_acc > PHASE_HALF) begin
					t = longint'(PHASE_HALF) - phase_acc;
				end else if (phase_acc < -PHASE_HALF) begin
					t = -longint'(PHASE_HALF) - phase_acc;
				end else begin
					t = longint'(phase_acc);
				end
				s = (2 * t * vol) >>> 14;
			end
			default: begin
				s = 0;
			end
		endcase

		// steps above 1.0 saturate; wrap by -2.0 once past +1.0
		stepv = longint'(step_q);
		if (stepv > PHASE_ONE) begin
			stepv = PHASE_ONE;
		end
		p = longint'(phase_acc) + stepv;
		if (p > PHASE_ONE) begin
			p = p - PHASE_TWO;
		end
		phase_acc = int'(p);

		for (k = 0; k < STAGES; k++) begin
			lo = longint'(low_st[k]);
			bd = longint'(band_st[k]);
			hi = clamp_word(s - ((bd * damp) >>> 14) - lo);
			bd = clamp_word(bd + ((hi * cut) >>> 16));
			lo = clamp_word(lo + ((bd * cut) >>> 16));
			low_st[k]  = int'(lo);
			band_st[k] = int'(bd);
			if (filt_sel == FILT_BAND) begin
				s = bd;
			end else if (filt_sel == FILT_HIGH) begin
				s = hi;
			end else begin
				s = lo;
			end
		end

		// positive side scales by 32767, the rest by 32768; truncate, clamp
		if (s > 0) begin
			y = (s * 32767) >>> 24;
		end else begin
			y = -((-s) >>> 9);
		end
		if (y > 32767) begin
			y = 32767;
		end else if (y < -32768) begin
			y = -32768;
		end
		res.audio = y[15:0];
		res.last  = (pos == 1);
		if (env_left > 0) begin
			env_left--;
		end
		return res;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r.kind       = ROW_WRITE;
		r.idx        = idx;
		r.data       = data;
		r.restart    = 1'b0;
		r.typed      = 1'b0;
		r.want.audio = '0;
		r.want.last  = 1'b0;
		stimulus_rows.push_back(r);
	endfunction

	function automatic void add_sample(input logic restart, input bit typed,
			input logic signed [15:0] audio, input logic last);
		row_t r;
		r.kind       = ROW_SAMPLE;
		r.idx        = '0;
		r.data       = '0;
		r.restart    = restart;
		r.typed      = typed;
		r.want.audio = audio;
		r.want.last  = last;
		stimulus_rows.push_back(r);
	endfunction

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// Drive one register write and track it in the bench settings. Leave the
	// enable high; the caller drops it after the last write of a batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_WAVE:     wave_sel  = data[1:0];
			REG_FILTER:   filt_sel  = data[1:0];
			REG_CUTOFF:   cutoff_q  = data[15:0];
			REG_DAMPING:  damping_q = data[15:0];
			REG_STEP:     step_q    = data[22:0];
			REG_NOTE_LEN: len_q     = data[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Drop the request and hold until every sample in flight has come back.
	task automatic wait_drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_samples.size() != 0);
	endtask

	// Offer one sample request, possibly after an idle gap, and record the
	// expected sample once the transaction is accepted. Valid stays high on
	// return so that a back-to-back request never toggles it within a step.
	task automatic send_sample(input logic restart, input bit typed,
			input sample_t want);
		int      gap;
		sample_t predicted;
		gap = 0;
		if (!steady_flow && $urandom_range(99) < 33) begin
			gap = $urandom_range(1, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		restart_note <= restart;
		do @(posedge clk); while (!in_ready);
		predicted = compute_sample(restart);
		expected_samples.push_back(typed ? want : predicted);
		samples_sent++;
	endtask

	// New random settings for a burst, extremes weighted up. Short notes
	// dominate so that notes run out and the end-of-note flag shows up.
	task automatic draw_settings;
		logic [CFG_DATA_W-1:0] stepv;
		logic [15:0]           lenv;
		wait_drain;
		case ($urandom_range(5))
			0:       stepv = CFG_DATA_W'(PHASE_ONE);
			1:       stepv = 23'h7FFFFF;
			2:       stepv = CFG_DATA_W'($urandom);
			3:       stepv = 23'd0;
			default: stepv = CFG_DATA_W'($urandom_range(1, 200000));
		endcase
		case ($urandom_range(7))
			0:       lenv = 16'd0;
			1:       lenv = 16'hFFFF;
			2:       lenv = 16'($urandom_range(16'hFFFF));
			default: lenv = 16'($urandom_range(1, 48));
		endcase
		write_reg(REG_WAVE, CFG_DATA_W'($urandom_range(3)));
		write_reg(REG_FILTER, CFG_DATA_W'($urandom_range(3)));
		write_reg(REG_CUTOFF, CFG_DATA_W'(pick_coeff()));
		write_reg(REG_DAMPING, CFG_DATA_W'(pick_coeff()));
		write_reg(REG_STEP, stepv);
		write_reg(REG_NOTE_LEN, CFG_DATA_W'(lenv));
		cfg_wr_en <= 1'b0;
	endtask

	// Check each returned sample against the oldest expectation, then roll
	// the sink stall for the next cycle.
	always @(posedge clk) begin : watch_samples
		sample_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: sample with none expected: audio_out %0d note_last %0b",
					$time, audio_out, note_last);
				mismatch_count++;
			end else begin
				want = expected_samples.pop_front();
				if (audio_out !== want.audio) begin
					$display("%0t: audio_out expected %0d, got %0d",
						$time, want.audio, audio_out);
					mismatch_count++;
				end
				if (note_last !== want.last) begin
					$display("%0t: note_last expected %0b, got %0b",
						$time, want.last, note_last);
					mismatch_count++;
				end
			end
		end
		out_ready <= steady_flow || ($urandom_range(99) >= 33);
	end

	initial begin
		sample_t blank;
		row_t    row;
		bit      writing;
		int      burst, n, i;
		blank.audio = '0;
		blank.last  = 1'b0;
		writing     = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. Silent after reset: no note running, filters at rest.
		add_sample(1'b0, 1'b1, 16'sd0, 1'b0);
		add_sample(1'b0, 1'b1, 16'sd0, 1'b0);
		// full-volume square note on the reset settings
		add_sample(1'b1, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// phase step above one saturates to 1.0
		add_write(REG_STEP, 23'h7FFFFF);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// saw and triangle on a phase step of 0.25
		add_write(REG_WAVE, CFG_DATA_W'(WAVE_SAW));
		add_write(REG_STEP, 23'h100000);
		add_sample(1'b1, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		add_write(REG_WAVE, CFG_DATA_W'(WAVE_TRI));
		add_sample(1'b0, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// unused waveform code gives a zero oscillator
		add_write(REG_WAVE, 23'd3);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// band and high filter taps, then the unused tap code
		add_write(REG_WAVE, CFG_DATA_W'(WAVE_SQUARE));
		add_write(REG_FILTER, CFG_DATA_W'(FILT_BAND));
		add_sample(1'b0, 1'b0, '0, 1'b0);
		add_write(REG_FILTER, CFG_DATA_W'(FILT_HIGH));
		add_sample(1'b0, 1'b0, '0, 1'b0);
		add_write(REG_FILTER, 23'd3);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// zero note length: silent, and a restart loads position zero
		add_write(REG_NOTE_LEN, 23'd0);
		add_sample(1'b1, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// one-sample note: last flag at once, then the envelope holds silent
		add_write(REG_NOTE_LEN, 23'd1);
		add_sample(1'b1, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// position beyond the length caps the ratio at 1.0
		add_write(REG_NOTE_LEN, 23'hFFFF);
		add_sample(1'b1, 1'b0, '0, 1'b0);
		add_write(REG_NOTE_LEN, 23'd2);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		// coefficient extremes
		add_write(REG_CUTOFF, 23'hFFFF);
		add_write(REG_DAMPING, 23'd0);
		add_sample(1'b1, 1'b0, '0, 1'b0);
		add_sample(1'b0, 1'b0, '0, 1'b0);
		add_write(REG_CUTOFF, 23'd0);
		add_write(REG_DAMPING, 23'hFFFF);
		add_sample(1'b0, 1'b0, '0, 1'b0);

		// Walk the table; settings change only once the core has gone idle.
		foreach (stimulus_rows[i]) begin
			row = stimulus_rows[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing) begin
					wait_drain;
					writing = 1'b1;
				end
				write_reg(row.idx, row.data);
			end else begin
				if (writing) begin
					cfg_wr_en <= 1'b0;
					writing = 1'b0;
				end
				send_sample(row.restart, row.typed, row.want);
			end
		end
		if (writing) begin
			cfg_wr_en <= 1'b0;
		end

		// Random bursts: each opens a fresh note, later restarts are sparse.
		// A few bursts in the middle run with no idling on either side.
		burst = 0;
		while (samples_sent < SAMPLE_TARGET) begin
			draw_settings;
			steady_flow = (burst >= 6 && burst <= 8);
			n = $urandom_range(20, 60);
			for (i = 0; i < n; i++) begin
				send_sample((i == 0) || ($urandom_range(99) < 8), 1'b0, blank);
			end
			burst++;
		end
		steady_flow = 1'b0;

		// Let the last samples return, then watch for strays.
		wait_drain;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_samples.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
